[rtl/ifft4_pkg.sv]
// widths, payload types and rounding helper for the four-point inverse fft butterfly
`default_nettype none

package ifft4_pkg;

  localparam int DW = 32;
  localparam int TW = 32;
  localparam int unsigned TW_FRAC = TW - 2;

  localparam int S1W = DW + 1;
  localparam int S2W = DW + 2;
  localparam int PW  = S2W + TW;
  localparam int P1W = PW + 1;
  localparam int LO_W = (P1W + 1) / 2;
  localparam int HI_W = P1W - LO_W;
  localparam int LPW = LO_W + 1 + TW;
  localparam int HPW = HI_W + TW;
  localparam int FPW = P1W + TW;
  localparam int Y3W = FPW + 1;
  localparam int RW  = Y3W + 1;

  typedef logic signed [DW-1:0]  data_t;
  typedef logic signed [TW-1:0]  tw_t;
  typedef logic signed [S1W-1:0] s1_t;
  typedef logic signed [S2W-1:0] s2_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [P1W-1:0] wide_t;
  typedef logic signed [LPW-1:0] lop_t;
  typedef logic signed [HPW-1:0] hip_t;
  typedef logic signed [FPW-1:0] full_t;
  typedef logic signed [Y3W-1:0] y3_t;
  typedef logic signed [RW-1:0]  rnd_t;

  localparam rnd_t SAT_MAX = {{(RW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam rnd_t SAT_MIN = {{(RW - DW + 1){1'b1}}, {(DW - 1){1'b0}}};

  typedef struct packed {
    data_t x0_re;
    data_t x0_im;
    data_t x1_re;
    data_t x1_im;
    data_t x2_re;
    data_t x2_im;
    data_t x3_re;
    data_t x3_im;
    tw_t   w1_re;
    tw_t   w1_im;
    tw_t   w2_re;
    tw_t   w2_im;
  } in_t;

  // y0 done, t feeds y2, f feeds y1, g feeds y3
  typedef struct packed {
    s2_t y0_re;
    s2_t y0_im;
    s2_t t_re;
    s2_t t_im;
    s2_t f_re;
    s2_t f_im;
    s2_t g_re;
    s2_t g_im;
    tw_t w1_re;
    tw_t w1_im;
    tw_t w2_re;
    tw_t w2_im;
  } front_t;

  typedef struct packed {
    s2_t   y0_re;
    s2_t   y0_im;
    wide_t y1_re;
    wide_t y1_im;
    wide_t y2_re;
    wide_t y2_im;
    wide_t h_re;
    wide_t h_im;
    tw_t   w2_re;
    tw_t   w2_im;
  } mid_t;

  typedef struct packed {
    data_t o0_re;
    data_t o0_im;
    data_t o1_re;
    data_t o1_im;
    data_t o2_re;
    data_t o2_im;
    data_t o3_re;
    data_t o3_im;
  } res_t;

  // round to nearest (ties up), shift right, saturate to the data width
  function automatic data_t rnd_sat(input rnd_t v, input int unsigned sh);
    rnd_t half;
    rnd_t r;
    half = (sh == 0) ? '0 : (rnd_t'(1) <<< (sh - 1));
    r = (v + half) >>> sh;
    if (r > SAT_MAX) begin
      return SAT_MAX[DW-1:0];
    end else if (r < SAT_MIN) begin
      return SAT_MIN[DW-1:0];
    end
    return r[DW-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/ifft4_front.sv]
// first two pipeline stages: stage-one sums and differences, then the pre-twiddle combinations
`default_nettype none

module ifft4_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ifft4_pkg::in_t    in_d,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ifft4_pkg::front_t      out_d
);
  import ifft4_pkg::*;

  logic v1;
  logic v2;
  logic rdy1;
  logic rdy2;

  s1_t s0_re, s0_im, s2_re, s2_im;
  s1_t d01_re, d01_im, d23_re, d23_im;
  tw_t w1_re, w1_im, w2_re, w2_im;
  front_t st2;

  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s0_re  <= S1W'($signed(in_d.x0_re)) + S1W'($signed(in_d.x1_re));
      s0_im  <= S1W'($signed(in_d.x0_im)) + S1W'($signed(in_d.x1_im));
      s2_re  <= S1W'($signed(in_d.x2_re)) + S1W'($signed(in_d.x3_re));
      s2_im  <= S1W'($signed(in_d.x2_im)) + S1W'($signed(in_d.x3_im));
      d01_re <= S1W'($signed(in_d.x0_re)) - S1W'($signed(in_d.x1_re));
      d01_im <= S1W'($signed(in_d.x0_im)) - S1W'($signed(in_d.x1_im));
      d23_re <= S1W'($signed(in_d.x2_re)) - S1W'($signed(in_d.x3_re));
      d23_im <= S1W'($signed(in_d.x2_im)) - S1W'($signed(in_d.x3_im));
      w1_re  <= in_d.w1_re;
      w1_im  <= in_d.w1_im;
      w2_re  <= in_d.w2_re;
      w2_im  <= in_d.w2_im;
    end
  end

  // f = d01 - i*d23 gives y1 after w1, g = d01 + i*d23 gives y3 after w1 and w2
  always_ff @(posedge clk) begin
    if (rdy2) begin
      st2.y0_re <= S2W'(s0_re) + S2W'(s2_re);
      st2.y0_im <= S2W'(s0_im) + S2W'(s2_im);
      st2.t_re  <= S2W'(s0_re) - S2W'(s2_re);
      st2.t_im  <= S2W'(s0_im) - S2W'(s2_im);
      st2.f_re  <= S2W'(d01_re) + S2W'(d23_im);
      st2.f_im  <= S2W'(d01_im) - S2W'(d23_re);
      st2.g_re  <= S2W'(d01_re) - S2W'(d23_im);
      st2.g_im  <= S2W'(d01_im) + S2W'(d23_re);
      st2.w1_re <= w1_re;
      st2.w1_im <= w1_im;
      st2.w2_re <= w2_re;
      st2.w2_im <= w2_im;
    end
  end

  assign out_valid = v2;
  assign out_d = st2;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !out_ready) |=> (v2 && $stable(st2)))
    else $error("front stage two lost or changed a stalled item");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && !out_ready))
    else $error("front dropped ready with a free stage");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(v2) |-> $past(v1))
    else $error("front stage two filled from an empty stage one");

endmodule

`default_nettype wire

[rtl/ifft4_cmul.sv]
// stages three and four: complex twiddle products for y1, y2 and the partial y3 term
`default_nettype none

module ifft4_cmul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ifft4_pkg::front_t  in_d,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ifft4_pkg::mid_t         out_d
);
  import ifft4_pkg::*;

  logic v3;
  logic v4;
  logic rdy3;
  logic rdy4;

  prod_t t_rr, t_ii, t_ri, t_ir;
  prod_t f_rr, f_ii, f_ri, f_ir;
  prod_t g_rr, g_ii, g_ri, g_ir;
  s2_t y0_re, y0_im;
  tw_t w2_re, w2_im;
  mid_t st4;

  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign in_ready = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy3) begin
        v3 <= in_valid;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      t_rr  <= PW'(in_d.t_re) * PW'(in_d.w2_re);
      t_ii  <= PW'(in_d.t_im) * PW'(in_d.w2_im);
      t_ri  <= PW'(in_d.t_re) * PW'(in_d.w2_im);
      t_ir  <= PW'(in_d.t_im) * PW'(in_d.w2_re);
      f_rr  <= PW'(in_d.f_re) * PW'(in_d.w1_re);
      f_ii  <= PW'(in_d.f_im) * PW'(in_d.w1_im);
      f_ri  <= PW'(in_d.f_re) * PW'(in_d.w1_im);
      f_ir  <= PW'(in_d.f_im) * PW'(in_d.w1_re);
      g_rr  <= PW'(in_d.g_re) * PW'(in_d.w1_re);
      g_ii  <= PW'(in_d.g_im) * PW'(in_d.w1_im);
      g_ri  <= PW'(in_d.g_re) * PW'(in_d.w1_im);
      g_ir  <= PW'(in_d.g_im) * PW'(in_d.w1_re);
      y0_re <= in_d.y0_re;
      y0_im <= in_d.y0_im;
      w2_re <= in_d.w2_re;
      w2_im <= in_d.w2_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      st4.y0_re <= y0_re;
      st4.y0_im <= y0_im;
      st4.y2_re <= P1W'(t_rr) - P1W'(t_ii);
      st4.y2_im <= P1W'(t_ri) + P1W'(t_ir);
      st4.y1_re <= P1W'(f_rr) - P1W'(f_ii);
      st4.y1_im <= P1W'(f_ri) + P1W'(f_ir);
      st4.h_re  <= P1W'(g_rr) - P1W'(g_ii);
      st4.h_im  <= P1W'(g_ri) + P1W'(g_ir);
      st4.w2_re <= w2_re;
      st4.w2_im <= w2_im;
    end
  end

  assign out_valid = v4;
  assign out_d = st4;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !out_ready) |=> (v4 && $stable(st4)))
    else $error("multiply stage four lost or changed a stalled item");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v3 && v4 && !out_ready))
    else $error("multiply stages dropped ready with a free stage");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(v4) |-> $past(v3))
    else $error("multiply stage four filled from an empty stage three");

endmodule

`default_nettype wire

[rtl/ifft4_wmul.sv]
// stages five to eight: split wide multiply for y3, rounding, saturation and the output register
`default_nettype none

module ifft4_wmul (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ifft4_pkg::mid_t  in_d,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ifft4_pkg::res_t       out_d
);
  import ifft4_pkg::*;

  logic v5, v6, v7, v8;
  logic rdy5, rdy6, rdy7, rdy8;

  logic signed [LO_W:0]   hr_lo, hi_lo;
  logic signed [HI_W-1:0] hr_hi, hi_hi;

  lop_t lp_rr, lp_ii, lp_ri, lp_ir;
  hip_t hp_rr, hp_ii, hp_ri, hp_ir;
  full_t fp_rr, fp_ii, fp_ri, fp_ir;
  y3_t y3_re, y3_im;
  res_t r5, r6, r7, r8;

  assign rdy8 = !v8 || out_ready;
  assign rdy7 = !v7 || rdy8;
  assign rdy6 = !v6 || rdy7;
  assign rdy5 = !v5 || rdy6;
  assign in_ready = rdy5;

  // h split into an unsigned low half and a signed high half
  assign hr_lo = $signed({1'b0, in_d.h_re[LO_W-1:0]});
  assign hi_lo = $signed({1'b0, in_d.h_im[LO_W-1:0]});
  assign hr_hi = in_d.h_re[P1W-1:LO_W];
  assign hi_hi = in_d.h_im[P1W-1:LO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (rdy5) begin
        v5 <= in_valid;
      end
      if (rdy6) begin
        v6 <= v5;
      end
      if (rdy7) begin
        v7 <= v6;
      end
      if (rdy8) begin
        v8 <= v7;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      lp_rr <= LPW'(hr_lo) * LPW'(in_d.w2_re);
      lp_ii <= LPW'(hi_lo) * LPW'(in_d.w2_im);
      lp_ri <= LPW'(hr_lo) * LPW'(in_d.w2_im);
      lp_ir <= LPW'(hi_lo) * LPW'(in_d.w2_re);
      hp_rr <= HPW'(hr_hi) * HPW'(in_d.w2_re);
      hp_ii <= HPW'(hi_hi) * HPW'(in_d.w2_im);
      hp_ri <= HPW'(hr_hi) * HPW'(in_d.w2_im);
      hp_ir <= HPW'(hi_hi) * HPW'(in_d.w2_re);
      r5.o0_re <= rnd_sat(RW'(in_d.y0_re), 0);
      r5.o0_im <= rnd_sat(RW'(in_d.y0_im), 0);
      r5.o1_re <= rnd_sat(RW'(in_d.y1_re), TW_FRAC);
      r5.o1_im <= rnd_sat(RW'(in_d.y1_im), TW_FRAC);
      r5.o2_re <= rnd_sat(RW'(in_d.y2_re), TW_FRAC);
      r5.o2_im <= rnd_sat(RW'(in_d.y2_im), TW_FRAC);
      r5.o3_re <= '0;
      r5.o3_im <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      fp_rr <= $signed({hp_rr, {LO_W{1'b0}}}) + FPW'(lp_rr);
      fp_ii <= $signed({hp_ii, {LO_W{1'b0}}}) + FPW'(lp_ii);
      fp_ri <= $signed({hp_ri, {LO_W{1'b0}}}) + FPW'(lp_ri);
      fp_ir <= $signed({hp_ir, {LO_W{1'b0}}}) + FPW'(lp_ir);
      r6 <= r5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      y3_re <= Y3W'(fp_rr) - Y3W'(fp_ii);
      y3_im <= Y3W'(fp_ri) + Y3W'(fp_ir);
      r7 <= r6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy8) begin
      r8.o0_re <= r7.o0_re;
      r8.o0_im <= r7.o0_im;
      r8.o1_re <= r7.o1_re;
      r8.o1_im <= r7.o1_im;
      r8.o2_re <= r7.o2_re;
      r8.o2_im <= r7.o2_im;
      r8.o3_re <= rnd_sat(RW'(y3_re), 2 * TW_FRAC);
      r8.o3_im <= rnd_sat(RW'(y3_im), 2 * TW_FRAC);
    end
  end

  assign out_valid = v8;
  assign out_d = r8;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v7 && !rdy7) |=> (v7 && $stable(y3_re) && $stable(y3_im) && $stable(r7)))
    else $error("stage seven lost or changed a stalled item");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v5 && v6 && v7 && v8 && !out_ready))
    else $error("back stages dropped ready with a free stage");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v7))
    else $error("output register filled from an empty stage seven");

endmodule

`default_nettype wire

[rtl/inverse_fft4_butterfly.sv]
// top level of the four-point inverse fft butterfly
`default_nettype none

// Four-point inverse FFT (radix-2, decimation in frequency) on Q15.16 data with
// Q1.30 twiddles w1 and w2. Full precision is kept through both butterfly
// stages; each result is rounded to nearest (ties up) and saturated to 32 bits.
// The block is an eight-stage pipeline with a valid bit per stage: it takes one
// transform per cycle while the output side is not stalled. A result is held in
// the output register of stage eight until the output side takes it.
// The depth is set by the twiddle products of stages three and four and by the
// 67 x 32 bit y3 product: its two halves are multiplied in stage five, joined in
// stage six, the complex terms are summed in stage seven and rounded in stage
// eight. Backpressure stalls only the full stages at the back, so bubbles are
// squeezed out and in_ready stays high while any stage is free.

module inverse_fft4_butterfly (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ifft4_pkg::data_t  in0_re,
  input  wire ifft4_pkg::data_t  in0_im,
  input  wire ifft4_pkg::data_t  in1_re,
  input  wire ifft4_pkg::data_t  in1_im,
  input  wire ifft4_pkg::data_t  in2_re,
  input  wire ifft4_pkg::data_t  in2_im,
  input  wire ifft4_pkg::data_t  in3_re,
  input  wire ifft4_pkg::data_t  in3_im,
  input  wire ifft4_pkg::tw_t    w1_re,
  input  wire ifft4_pkg::tw_t    w1_im,
  input  wire ifft4_pkg::tw_t    w2_re,
  input  wire ifft4_pkg::tw_t    w2_im,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ifft4_pkg::data_t       out0_re,
  output ifft4_pkg::data_t       out0_im,
  output ifft4_pkg::data_t       out1_re,
  output ifft4_pkg::data_t       out1_im,
  output ifft4_pkg::data_t       out2_re,
  output ifft4_pkg::data_t       out2_im,
  output ifft4_pkg::data_t       out3_re,
  output ifft4_pkg::data_t       out3_im
);
  import ifft4_pkg::*;

  in_t    in_d;
  front_t front_d;
  mid_t   mid_d;
  res_t   res_d;
  logic   front_valid, front_ready;
  logic   mid_valid, mid_ready;

  assign in_d.x0_re = in0_re;
  assign in_d.x0_im = in0_im;
  assign in_d.x1_re = in1_re;
  assign in_d.x1_im = in1_im;
  assign in_d.x2_re = in2_re;
  assign in_d.x2_im = in2_im;
  assign in_d.x3_re = in3_re;
  assign in_d.x3_im = in3_im;
  assign in_d.w1_re = w1_re;
  assign in_d.w1_im = w1_im;
  assign in_d.w2_re = w2_re;
  assign in_d.w2_im = w2_im;

  ifft4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_d      (in_d),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_d     (front_d)
  );

  ifft4_cmul u_cmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_d      (front_d),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_d     (mid_d)
  );

  ifft4_wmul u_wmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_d      (mid_d),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_d     (res_d)
  );

  assign out0_re = res_d.o0_re;
  assign out0_im = res_d.o0_im;
  assign out1_re = res_d.o1_re;
  assign out1_im = res_d.o1_im;
  assign out2_re = res_d.o2_re;
  assign out2_im = res_d.o2_im;
  assign out3_re = res_d.o3_re;
  assign out3_im = res_d.o3_im;

endmodule

`default_nettype wire
